// File: rtl/core/r2fft_pkg.sv
package r2fft_pkg;

    localparam int Points     = 128;
    localparam int AddrBits   = $clog2(Points);
    localparam int StageBits  = 3;
    localparam int SampleBits = 12;
    localparam int StoreBits  = 21;
    localparam int OutBits    = 20;
    localparam int CoefBits   = 16;
    localparam int ProdBits   = StoreBits + CoefBits + 1;

    typedef logic signed [StoreBits-1:0] store_t;

    typedef struct packed {
        store_t re;
        store_t im;
    } cplx_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD,
        ST_MUL,
        ST_WRA,
        ST_WRB,
        ST_ERD,
        ST_EMIT
    } state_t;

    // Quarter-wave Q1.15 cosine, unity clipped to 32767.
    function automatic logic signed [CoefBits-1:0] cos_q15(input logic [5:0] k);
        logic signed [CoefBits-1:0] v;
        case (k)
            6'd0: v = 16'sd32767;   6'd1: v = 16'sd32729;   6'd2: v = 16'sd32610;
            6'd3: v = 16'sd32413;   6'd4: v = 16'sd32138;   6'd5: v = 16'sd31786;
            6'd6: v = 16'sd31357;   6'd7: v = 16'sd30853;   6'd8: v = 16'sd30274;
            6'd9: v = 16'sd29622;   6'd10: v = 16'sd28899;  6'd11: v = 16'sd28106;
            6'd12: v = 16'sd27246;  6'd13: v = 16'sd26320;  6'd14: v = 16'sd25330;
            6'd15: v = 16'sd24279;  6'd16: v = 16'sd23170;  6'd17: v = 16'sd22006;
            6'd18: v = 16'sd20788;  6'd19: v = 16'sd19520;  6'd20: v = 16'sd18205;
            6'd21: v = 16'sd16846;  6'd22: v = 16'sd15447;  6'd23: v = 16'sd14010;
            6'd24: v = 16'sd12540;  6'd25: v = 16'sd11039;  6'd26: v = 16'sd9512;
            6'd27: v = 16'sd7962;   6'd28: v = 16'sd6393;   6'd29: v = 16'sd4808;
            6'd30: v = 16'sd3212;   6'd31: v = 16'sd1608;   default: v = 16'sd0;
        endcase
        return v;
    endfunction

    function automatic logic [AddrBits-1:0] bit_rev(input logic [AddrBits-1:0] v);
        logic [AddrBits-1:0] r;
        for (int i = 0; i < AddrBits; i++) begin
            r[i] = v[AddrBits-1-i];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/r2fft_ram.sv
module r2fft_ram
    import r2fft_pkg::*;
(
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [AddrBits-1:0] wr_addr,
    input  cplx_t               wr_data,
    input  logic [AddrBits-1:0] rd_addr,
    output cplx_t               rd_data
);

    cplx_t mem [Points];
    cplx_t rd_data_reg;

    // One write and one registered read each cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/r2fft_bfly.sv
module r2fft_bfly
    import r2fft_pkg::*;
(
    input  logic                aclk,
    input  logic                load,
    input  logic [5:0]          tw_idx,
    input  cplx_t               b_in,
    input  cplx_t               a_in,
    output cplx_t               sum_out,
    output cplx_t               diff_out
);

    logic signed [CoefBits-1:0] c_reg, s_reg, c_next, s_next;
    logic                       bypass_reg;
    logic signed [ProdBits-1:0] zr_sum, zi_sum;
    logic signed [ProdBits-1:0] zr_rnd, zi_rnd;
    logic signed [StoreBits:0]  zr, zi;
    store_t                     br_reg, bi_reg;
    logic signed [StoreBits+1:0] sr, si, dr, di;

    // Twiddle lookup, W = cos - j*sin.
    always_comb begin
        if (tw_idx <= 6'd32) begin
            c_next = cos_q15(tw_idx);
            s_next = cos_q15(6'd32 - tw_idx);
        end else begin
            c_next = -cos_q15(6'd0 - tw_idx);
            s_next = cos_q15(tw_idx - 6'd32);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            c_reg      <= c_next;
            s_reg      <= s_next;
            bypass_reg <= (tw_idx == 6'd0);
            br_reg     <= b_in.re;
            bi_reg     <= b_in.im;
        end
    end

    // Complex product with round to nearest, ties upward.
    assign zr_sum = ProdBits'(c_reg) * ProdBits'(br_reg) + ProdBits'(s_reg) * ProdBits'(bi_reg);
    assign zi_sum = ProdBits'(c_reg) * ProdBits'(bi_reg) - ProdBits'(s_reg) * ProdBits'(br_reg);
    assign zr_rnd = (zr_sum + ProdBits'(16384)) >>> 15;
    assign zi_rnd = (zi_sum + ProdBits'(16384)) >>> 15;
    assign zr = bypass_reg ? (StoreBits+1)'(br_reg) : zr_rnd[StoreBits:0];
    assign zi = bypass_reg ? (StoreBits+1)'(bi_reg) : zi_rnd[StoreBits:0];

    assign sr = (StoreBits+2)'(a_in.re) + (StoreBits+2)'(zr);
    assign si = (StoreBits+2)'(a_in.im) + (StoreBits+2)'(zi);
    assign dr = (StoreBits+2)'(a_in.re) - (StoreBits+2)'(zr);
    assign di = (StoreBits+2)'(a_in.im) - (StoreBits+2)'(zi);

    function automatic store_t sat(input logic signed [StoreBits+1:0] v);
        store_t r;
        if (v > (StoreBits+2)'(1048575)) r = store_t'(1048575);
        else if (v < -(StoreBits+2)'(1048576)) r = store_t'(-1048576);
        else r = v[StoreBits-1:0];
        return r;
    endfunction

    assign sum_out.re  = sat(sr);
    assign sum_out.im  = sat(si);
    assign diff_out.re = sat(dr);
    assign diff_out.im = sat(di);

endmodule

// File: rtl/core/radix2_fft_real_frame_core.sv
// A frame of 128 samples is gathered one per cycle, while s_tvalid is high, into
// a single-port-write, registered-read frame memory in bit-reversed order, after
// which the input stalls while seven in-place radix-2 stages run (448 butterflies,
// each stepping through read a, read b, twiddle load, write a, write b) and the 64
// bins are emitted in order, each read from memory and then registered, waiting while
// an earlier bin is still not taken; last is set on bin 63. Results saturate to 20 bits.
module radix2_fft_real_frame_core
    import r2fft_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [5:0] bin_index, [25:6] bin_real, [45:26] bin_imag
    output logic        m_tlast    // last_bin
);

    state_t              state_reg, state_next;
    logic [AddrBits-1:0] cnt_reg, cnt_next;
    logic [StageBits-1:0] stage_reg, stage_next;
    logic [5:0]          bf_reg, bf_next;
    cplx_t               a_reg;
    logic                a_ld;
    logic                out_valid_reg;
    logic [5:0]          out_idx_reg;
    store_t              out_re_reg, out_im_reg;
    logic                out_ld;

    logic                wr_en;
    logic [AddrBits-1:0] wr_addr, rd_addr;
    cplx_t               wr_data, rd_data, sum_c, diff_c;
    logic                bf_ld;

    // Butterfly addressing from stage and butterfly counter.
    logic [AddrBits-1:0] half, low_mask, addr_a, addr_b;
    logic [5:0]          tw_idx;
    assign half     = AddrBits'(1) << stage_reg;
    assign low_mask = half - AddrBits'(1);
    assign addr_a   = ((AddrBits'(bf_reg) & ~low_mask) << 1) | (AddrBits'(bf_reg) & low_mask);
    assign addr_b   = addr_a | half;
    assign tw_idx   = 6'((AddrBits'(bf_reg) & low_mask) << (3'd6 - stage_reg));

    r2fft_ram u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    r2fft_bfly u_bfly (
        .aclk     (aclk),
        .load     (bf_ld),
        .tw_idx   (tw_idx),
        .b_in     (rd_data),
        .a_in     (a_reg),
        .sum_out  (sum_c),
        .diff_out (diff_c)
    );

    // Sequencer registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            stage_reg     <= '0;
            bf_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            stage_reg <= stage_next;
            bf_reg    <= bf_next;
            if (out_ld) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (a_ld) begin
            a_reg <= rd_data;
        end
        if (out_ld) begin
            out_idx_reg <= cnt_reg[5:0];
            out_re_reg  <= rd_data.re;
            out_im_reg  <= rd_data.im;
        end
    end

    // Next state and memory control.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        stage_next = stage_reg;
        bf_next    = bf_reg;
        s_tready   = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = addr_a;
        wr_data    = sum_c;
        rd_addr    = addr_a;
        a_ld       = 1'b0;
        bf_ld      = 1'b0;
        out_ld     = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_tready     = 1'b1;
                wr_addr      = bit_rev(cnt_reg);
                wr_data.re   = store_t'(s_tdata[SampleBits-1:0]);
                wr_data.im   = '0;
                if (s_tvalid) begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg + AddrBits'(1);
                    if (cnt_reg == AddrBits'(Points-1)) begin
                        state_next = ST_RD;
                        stage_next = '0;
                        bf_next    = '0;
                    end
                end
            end
            ST_RD: begin
                // Read a, then b.
                rd_addr    = addr_a;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                rd_addr    = addr_b;
                a_ld       = 1'b1;
                state_next = ST_WRA;
            end
            ST_WRA: begin
                bf_ld      = 1'b1;
                state_next = ST_WRB;
            end
            ST_WRB: begin
                wr_en      = 1'b1;
                wr_addr    = addr_a;
                wr_data    = sum_c;
                state_next = ST_ERD;
            end
            ST_ERD: begin
                if (stage_reg != StageBits'(AddrBits)) begin
                    // Second write of the butterfly.
                    wr_en   = 1'b1;
                    wr_addr = addr_b;
                    wr_data = diff_c;
                    bf_next = bf_reg + 6'd1;
                    state_next = ST_RD;
                    if (bf_reg == 6'(Points/2-1)) begin
                        stage_next = stage_reg + StageBits'(1);
                        if (stage_reg == StageBits'(AddrBits-1)) begin
                            stage_next = StageBits'(AddrBits);
                            cnt_next   = '0;
                            state_next = ST_ERD;
                        end
                    end
                end else begin
                    // Output phase: read bin, wait here until the output register is free, then load it in emit.
                    rd_addr = cnt_reg;
                    if (!out_valid_reg || m_tready) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                out_ld   = 1'b1;
                cnt_next = cnt_reg + AddrBits'(1);
                if (cnt_reg == AddrBits'(Points/2-1)) begin
                    cnt_next   = '0;
                    stage_next = '0;
                    state_next = ST_LOAD;
                end else begin
                    state_next = ST_ERD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // Saturate to the result width.
    function automatic logic [OutBits-1:0] osat(input store_t v);
        logic [OutBits-1:0] r;
        if (v > store_t'(524287)) r = OutBits'(524287);
        else if (v < store_t'(-524288)) r = OutBits'(-524288);
        else r = v[OutBits-1:0];
        return r;
    endfunction

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, osat(out_im_reg), osat(out_re_reg), out_idx_reg};
    assign m_tlast  = (out_idx_reg == 6'(Points/2-1));

endmodule

// File: verif/radix2_fft_real_frame_checker.sv
module radix2_fft_real_frame_checker
    import r2fft_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          bins_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [5:0]         idx;
        logic signed [19:0] re;
        logic signed [19:0] im;
        logic               last;
    } bin_t;

    // Local copy of the frame memory and fill position.
    longint frame_re[Points];
    longint frame_im[Points];
    int     fill_pos;
    bin_t   expected_bins[$];

    localparam int CosTab[33] = '{
        32767, 32729, 32610, 32413, 32138, 31786, 31357, 30853,
        30274, 29622, 28899, 28106, 27246, 26320, 25330, 24279,
        23170, 22006, 20788, 19520, 18205, 16846, 15447, 14010,
        12540, 11039, 9512, 7962, 6393, 4808, 3212, 1608, 0};

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Round to nearest with ties upwards, as floor((x + 2^14) / 2^15).
    function automatic longint q15_round(longint x);
        return (x + 16384) >>> 15;
    endfunction

    // In-place decimation-in-time stages over the stored frame.
    task automatic transform_frame();
        longint br, bi, er, ei, zr, zi, c, s;
        int half, t, a, b;
        for (int len = 2; len <= Points; len = len * 2) begin
            half = len / 2;
            for (int base = 0; base < Points; base += len) begin
                for (int m = 0; m < half; m++) begin
                    t  = (m * (128 / len)) & 63;
                    a  = base + m;
                    b  = base + m + half;
                    br = frame_re[b]; bi = frame_im[b];
                    er = frame_re[a]; ei = frame_im[a];
                    if (t == 0) begin
                        zr = br; zi = bi;
                    end else begin
                        if (t <= 32) begin
                            c = CosTab[t]; s = CosTab[32 - t];
                        end else begin
                            c = -CosTab[64 - t]; s = CosTab[t - 32];
                        end
                        zr = q15_round(c * br + s * bi);
                        zi = q15_round(c * bi - s * br);
                    end
                    frame_re[a] = clamp(er + zr, -1048576, 1048575);
                    frame_im[a] = clamp(ei + zi, -1048576, 1048575);
                    frame_re[b] = clamp(er - zr, -1048576, 1048575);
                    frame_im[b] = clamp(ei - zi, -1048576, 1048575);
                end
            end
        end
    endtask

    // Store one sample and, on a full frame, queue the expected bins.
    task automatic take_sample(logic [15:0] word);
        bin_t   e;
        logic [6:0] addr;
        logic [6:0] pos;
        pos = fill_pos[6:0];
        for (int i = 0; i < 7; i++) addr[i] = pos[6 - i];
        frame_re[addr] = word[11:0];
        frame_im[addr] = 0;
        fill_pos++;
        if (fill_pos == Points) begin
            fill_pos = 0;
            transform_frame();
            for (int k = 0; k < Points / 2; k++) begin
                e.idx  = k[5:0];
                e.re   = 20'(clamp(frame_re[k], -524288, 524287));
                e.im   = 20'(clamp(frame_im[k], -524288, 524287));
                e.last = (k == Points / 2 - 1);
                expected_bins.push_back(e);
            end
        end
    endtask

    assign bins_pending = expected_bins.size();

    // Watch both channels and compare each result transaction.
    always @(posedge aclk) begin
        bin_t e;
        if (!aresetn) begin
            fill_pos   = 0;
            fail_count = 0;
            expected_bins.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_bins.size() == 0) begin
                    $display("%0t: unexpected bin, actual %h", $time, m_tdata);
                    fail_count++;
                end else begin
                    e = expected_bins.pop_front();
                    if (m_tdata[5:0] !== e.idx || m_tdata[25:6] !== e.re
                        || m_tdata[45:26] !== e.im || m_tlast !== e.last) begin
                        $display("%0t: bin mismatch, expected idx %0d re %0d im %0d last %0b",
                                 $time, e.idx, e.re, e.im, e.last);
                        $display("%0t:               actual idx %0d re %0d im %0d last %0b",
                                 $time, m_tdata[5:0], $signed(m_tdata[25:6]),
                                 $signed(m_tdata[45:26]), m_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) take_sample(s_tdata);
        end
    end
endmodule

// File: verif/radix2_fft_real_frame_core_tb.sv
module radix2_fft_real_frame_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [47:0] m_tdata;
    logic        m_tlast;
    int          fail_count;
    int          bins_pending;
    int          cycle_count = 0;
    bit          hold_sink = 0;

    localparam int CycleLimit = 400000;

    always #5 aclk = ~aclk;

    radix2_fft_real_frame_core dut (.*);

    radix2_fft_real_frame_checker checker_i (.*);

    // Run guard.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result sink with random stalls, plus one long hold-off.
    initial begin
        int gap;
        repeat (3) @(posedge aclk);
        forever begin
            gap = $urandom_range(0, 5);
            if ((cycle_count / 4000) % 3 == 1) gap = 0;
            if (hold_sink) gap = 3000;
            hold_sink = 0;
            if (gap > 0) begin
                m_tready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Offer one sample and wait for its transaction.
    task automatic send_sample(logic [15:0] word, int gap);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Frame one: extremes and walking bits, padded with zero.
        send_sample(16'h0FFF, 0);
        send_sample(16'h0000, 1);
        send_sample(16'hF000, 0);
        send_sample(16'hFFFF, 2);
        for (int b = 0; b < 16; b++) send_sample(16'(1 << b), 0);
        for (int i = 20; i < 128; i++) send_sample(16'h0000, $urandom_range(0, 5));

        // Frame two: full-scale constant, giving the largest possible DC bin.
        // The long receiver hold-off begins here so the input stalls behind it.
        hold_sink = 1;
        for (int i = 0; i < 128; i++) send_sample(16'h0FFF, 0);

        // A partial frame of noise that never completes.
        for (int i = 0; i < 54; i++) send_sample(16'($urandom()), $urandom_range(0, 5));
        s_tvalid <= 0;

        while (bins_pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// File: sim.f
rtl/core/r2fft_pkg.sv
rtl/core/r2fft_ram.sv
rtl/core/r2fft_bfly.sv
rtl/core/radix2_fft_real_frame_core.sv
verif/radix2_fft_real_frame_checker.sv
verif/radix2_fft_real_frame_core_tb.sv
